>>> sv/scpwm_pkg.sv
// ----------------------------------------------------------------------------
// scpwm_pkg
// shared types and register map constants for the sixteen-channel pwm device
// ----------------------------------------------------------------------------
package scpwm_pkg;

	typedef enum logic [1:0] {
		CMD_TICK  = 2'd0,
		CMD_PTR   = 2'd1,
		CMD_WRITE = 2'd2,
		CMD_READ  = 2'd3
	} cmd_t;

	// register map
	localparam logic [7:0] ADDR_MODE1    = 8'h00;
	localparam logic [7:0] ADDR_MODE2    = 8'h01;
	localparam logic [7:0] ADDR_LED_BASE = 8'h06;
	localparam logic [7:0] ADDR_ALL_BASE = 8'hFA;
	localparam logic [7:0] ADDR_PRESCALE = 8'hFE;

	// mode bits
	localparam int M1_SLEEP_BIT = 4;
	localparam int M1_AI_BIT    = 5;
	localparam int M2_INVRT_BIT = 4;

	// on/off count words: flag bit above twelve count bits
	localparam int CNT_W     = 13;
	localparam int FULL_BIT  = 12;
	localparam int HI_BITS   = 5;

	localparam logic [7:0] PRESCALE_MIN = 8'h03;

	// reset values
	localparam logic [6:0]       MODE1_RST    = 7'h11;
	localparam logic [4:0]       MODE2_RST    = 5'h04;
	localparam logic [7:0]       PRESCALE_RST = 8'd30;
	localparam logic [CNT_W-1:0] ON_RST       = 13'h0000;
	localparam logic [CNT_W-1:0] OFF_RST      = 13'h1000;

	localparam int PWM_W   = 16;
	localparam int PHASE_W = 12;

endpackage

>>> sv/scpwm_levels.sv
// ----------------------------------------------------------------------------
// scpwm_levels
// channel level compare: each channel against its on/off counts, then invert
// ----------------------------------------------------------------------------
module scpwm_levels #(
	parameter int CHANNELS   = 16,
	parameter int COUNT_BITS = 12
) (
	input  logic [CHANNELS-1:0][scpwm_pkg::CNT_W-1:0] on_cnt,
	input  logic [CHANNELS-1:0][scpwm_pkg::CNT_W-1:0] off_cnt,
	input  logic [COUNT_BITS-1:0]                     count,
	input  logic                                      invert,
	output logic [scpwm_pkg::PWM_W-1:0]               lines
);
	import scpwm_pkg::*;

	logic [CHANNELS-1:0] lv;

	always_comb begin
		logic [COUNT_BITS-1:0] lo;
		logic [COUNT_BITS-1:0] hi;
		logic                  raw;
		for (int ch = 0; ch < CHANNELS; ch++) begin
			lo = on_cnt[ch][COUNT_BITS-1:0];
			hi = off_cnt[ch][COUNT_BITS-1:0];
			if (off_cnt[ch][FULL_BIT]) begin
				raw = 1'b0;
			end else if (on_cnt[ch][FULL_BIT]) begin
				raw = 1'b1;
			end else if (lo < hi) begin
				raw = (count >= lo) && (count < hi);
			end else if (lo > hi) begin
				// window wraps through zero
				raw = (count >= lo) || (count < hi);
			end else begin
				raw = 1'b0;
			end
			lv[ch] = raw ^ invert;
		end
	end

	assign lines = PWM_W'(lv);

endmodule

>>> sv/sixteen_channel_pwm_register_device.sv
// ----------------------------------------------------------------------------
// sixteen_channel_pwm_register_device
// byte-wide register device driving up to sixteen pwm channels
// ----------------------------------------------------------------------------
// Each command word (tick, pointer load, byte write, byte read) gives exactly
// one response word carrying the read byte, the channel levels and the period
// counter as they stand after that command. A word goes through an input
// register and then a result register, from which its response is driven. One
// command is taken every cycle while the response side keeps up. The path
// between the two registers is the register decode and the per-channel
// on/off compare. cmd_stall rises only while a response is held by
// rsp_stall and the input register is full.
module sixteen_channel_pwm_register_device #(
	parameter int CHANNELS   = 16,
	parameter int COUNT_BITS = 12
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cmd_valid,
	output logic                                cmd_stall,
	input  logic [1:0]                          cmd,
	input  logic [7:0]                          reg_addr,
	input  logic [7:0]                          wr_data,
	output logic                                rsp_valid,
	input  logic                                rsp_stall,
	output logic [7:0]                          rd_data,
	output logic [scpwm_pkg::PWM_W-1:0]         pwm_lines,
	output logic [scpwm_pkg::PHASE_W-1:0]       phase_count
);
	import scpwm_pkg::*;

	// input register
	logic       valid_s1;
	cmd_t       cmd_s1;
	logic [7:0] addr_s1;
	logic [7:0] data_s1;

	// device state
	logic [6:0]                         mode1_q, mode1_d;
	logic [4:0]                         mode2_q, mode2_d;
	logic [7:0]                         ptr_q, ptr_d;
	logic [7:0]                         pre_q, pre_d;
	logic [7:0]                         pcnt_q, pcnt_d;
	logic [COUNT_BITS-1:0]              period_q, period_d;
	logic [CHANNELS-1:0][CNT_W-1:0]     on_q, on_d;
	logic [CHANNELS-1:0][CNT_W-1:0]     off_q, off_d;

	// result register
	logic                   rsp_valid_q;
	logic [7:0]             rd_q;
	logic [PWM_W-1:0]       lines_q;
	logic [PHASE_W-1:0]     phase_q;

	logic             adv;
	logic [7:0]       rd_d;
	logic [PWM_W-1:0] lines_d;

	assign adv       = !rsp_valid_q || !rsp_stall;
	assign cmd_stall = valid_s1 && !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!cmd_stall) begin
			valid_s1 <= cmd_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_valid && !cmd_stall) begin
			cmd_s1  <= cmd_t'(cmd);
			addr_s1 <= reg_addr;
			data_s1 <= wr_data;
		end
	end

	// next state for the word in the input register
	always_comb begin
		logic [7:0] led_off;
		logic       led_hit;
		logic       all_hit;
		logic [1:0] sel;
		logic [7:0] v;

		mode1_d  = mode1_q;
		mode2_d  = mode2_q;
		ptr_d    = ptr_q;
		pre_d    = pre_q;
		pcnt_d   = pcnt_q;
		period_d = period_q;
		on_d     = on_q;
		off_d    = off_q;
		rd_d     = 8'h00;
		sel      = 2'd0;

		led_off = ptr_q - ADDR_LED_BASE;
		led_hit = (ptr_q >= ADDR_LED_BASE) && (led_off < 8'(4 * CHANNELS));
		all_hit = (ptr_q >= ADDR_ALL_BASE) && (ptr_q < ADDR_PRESCALE);
		v       = data_s1;

		case (cmd_s1)
			CMD_TICK: begin
				if (!mode1_q[M1_SLEEP_BIT]) begin
					if (pcnt_q >= pre_q) begin
						pcnt_d   = 8'h00;
						period_d = period_q + 1'b1;
					end else begin
						pcnt_d = pcnt_q + 8'd1;
					end
				end
			end
			CMD_PTR: begin
				ptr_d = addr_s1;
			end
			CMD_WRITE: begin
				if (ptr_q == ADDR_MODE1) begin
					mode1_d = v[6:0];
				end else if (ptr_q == ADDR_MODE2) begin
					mode2_d = v[4:0];
				end else if (ptr_q == ADDR_PRESCALE) begin
					if (mode1_q[M1_SLEEP_BIT]) begin
						pre_d = (v < PRESCALE_MIN) ? PRESCALE_MIN : v;
					end
				end
				// all_led bytes map FA..FD onto select 0..3
				sel = all_hit ? (ptr_q[1:0] + 2'd2) : led_off[1:0];
				for (int ch = 0; ch < CHANNELS; ch++) begin
					if (all_hit || (led_hit && led_off[7:2] == 6'(ch))) begin
						case (sel)
							2'd0:    on_d[ch][7:0]        = v;
							2'd1:    on_d[ch][CNT_W-1:8]  = v[HI_BITS-1:0];
							2'd2:    off_d[ch][7:0]       = v;
							default: off_d[ch][CNT_W-1:8] = v[HI_BITS-1:0];
						endcase
					end
				end
				if (mode1_d[M1_AI_BIT]) begin
					ptr_d = ptr_q + 8'd1;
				end
			end
			default: begin
				if (ptr_q == ADDR_MODE1) begin
					rd_d = {1'b0, mode1_q};
				end else if (ptr_q == ADDR_MODE2) begin
					rd_d = {3'b000, mode2_q};
				end else if (ptr_q == ADDR_PRESCALE) begin
					rd_d = pre_q;
				end else if (led_hit) begin
					for (int ch = 0; ch < CHANNELS; ch++) begin
						if (led_off[7:2] == 6'(ch)) begin
							case (led_off[1:0])
								2'd0:    rd_d = on_q[ch][7:0];
								2'd1:    rd_d = {3'b000, on_q[ch][CNT_W-1:8]};
								2'd2:    rd_d = off_q[ch][7:0];
								default: rd_d = {3'b000, off_q[ch][CNT_W-1:8]};
							endcase
						end
					end
				end
				if (mode1_q[M1_AI_BIT]) begin
					ptr_d = ptr_q + 8'd1;
				end
			end
		endcase
	end

	scpwm_levels #(
		.CHANNELS   (CHANNELS),
		.COUNT_BITS (COUNT_BITS)
	) u_levels (
		.on_cnt  (on_d),
		.off_cnt (off_d),
		.count   (period_d),
		.invert  (mode2_d[M2_INVRT_BIT]),
		.lines   (lines_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode1_q  <= MODE1_RST;
			mode2_q  <= MODE2_RST;
			ptr_q    <= 8'h00;
			pre_q    <= PRESCALE_RST;
			pcnt_q   <= 8'h00;
			period_q <= '0;
			for (int ch = 0; ch < CHANNELS; ch++) begin
				on_q[ch]  <= ON_RST;
				off_q[ch] <= OFF_RST;
			end
		end else if (valid_s1 && adv) begin
			mode1_q  <= mode1_d;
			mode2_q  <= mode2_d;
			ptr_q    <= ptr_d;
			pre_q    <= pre_d;
			pcnt_q   <= pcnt_d;
			period_q <= period_d;
			on_q     <= on_d;
			off_q    <= off_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (adv) begin
			rsp_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && adv) begin
			rd_q    <= rd_d;
			lines_q <= lines_d;
			phase_q <= PHASE_W'(period_d);
		end
	end

	assign rsp_valid   = rsp_valid_q;
	assign rd_data     = rd_q;
	assign pwm_lines   = lines_q;
	assign phase_count = phase_q;

endmodule

>>> sv/scpwm_chk.sv
// ----------------------------------------------------------------------------
// scpwm_chk
// port-level checks for the sixteen-channel pwm device, bound to the top
// ----------------------------------------------------------------------------
module scpwm_chk #(
	parameter int CHANNELS   = 16,
	parameter int COUNT_BITS = 12
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          cmd_stall,
	input logic                          rsp_valid,
	input logic                          rsp_stall,
	input logic [7:0]                    rd_data,
	input logic [scpwm_pkg::PWM_W-1:0]   pwm_lines,
	input logic [scpwm_pkg::PHASE_W-1:0] phase_count
);
	import scpwm_pkg::*;

	localparam logic [PWM_W:0]   LINES_LIMIT = (PWM_W+1)'(1) << CHANNELS;
	localparam logic [PHASE_W:0] PHASE_LIMIT = (PHASE_W+1)'(1) << COUNT_BITS;

	// held response keeps its word
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rd_data) &&
			$stable(pwm_lines) && $stable(phase_count))
		else $error("held response changed");

	// command side only backs up behind a stalled response
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_stall |-> rsp_valid && rsp_stall)
		else $error("command stalled without response backpressure");

	// unused channel lines stay low
	a_lines_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> {1'b0, pwm_lines} < LINES_LIMIT)
		else $error("line beyond channel count driven");

	// period counter stays within its width
	a_phase_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> {1'b0, phase_count} < PHASE_LIMIT)
		else $error("period counter out of range");

endmodule

bind sixteen_channel_pwm_register_device scpwm_chk #(
	.CHANNELS   (CHANNELS),
	.COUNT_BITS (COUNT_BITS)
) u_scpwm_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.cmd_stall   (cmd_stall),
	.rsp_valid   (rsp_valid),
	.rsp_stall   (rsp_stall),
	.rd_data     (rd_data),
	.pwm_lines   (pwm_lines),
	.phase_count (phase_count)
);
